// ----- src/slxfp_pkg.sv -----
package slxfp_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SYNC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SYNC = 2'd1;

   localparam logic [7:0] FIRST_SYNC_RESET  = 8'd170;
   localparam logic [7:0] SECOND_SYNC_RESET = 8'd85;

   // Result word: payload byte, byte index and frame length, padded to bytes.
   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 5;
   localparam int FLEN_W      = 6;
   localparam int RSP_FIELD_W = BYTE_W + INDEX_W + FLEN_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_SYNC0,
      ST_SYNC1,
      ST_LEN,
      ST_DATA,
      ST_CHECK,
      ST_READ,
      ST_EMIT
   } slxfp_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_len;
      logic take_byte;
      logic start_replay;
      logic read_entry;
      logic emit;
   } slxfp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sync0_hit;
      logic sync1_hit;
      logic len_ok;
      logic data_done;
      logic xor_hit;
      logic last_entry;
      logic out_free;
   } slxfp_status_type;

endpackage

// ----- src/slxfp_ctrl.sv -----
module slxfp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  slxfp_pkg::slxfp_status_type status,
   output slxfp_pkg::slxfp_cmd_type    cmd
);

   slxfp_pkg::slxfp_state_type state_ff;
   slxfp_pkg::slxfp_state_type state_in;
   logic                       accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slxfp_pkg::ST_SYNC0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slxfp_pkg::ST_SYNC0: begin
            if (accept) begin
               state_in = status.sync0_hit ? slxfp_pkg::ST_SYNC1 : slxfp_pkg::ST_SYNC0;
            end
         end
         slxfp_pkg::ST_SYNC1: begin
            // A wrong second byte is not retried as a first sync byte.
            if (accept) begin
               state_in = status.sync1_hit ? slxfp_pkg::ST_LEN : slxfp_pkg::ST_SYNC0;
            end
         end
         slxfp_pkg::ST_LEN: begin
            if (accept) begin
               state_in = status.len_ok ? slxfp_pkg::ST_DATA : slxfp_pkg::ST_SYNC0;
            end
         end
         slxfp_pkg::ST_DATA: begin
            if (accept && status.data_done) begin
               state_in = slxfp_pkg::ST_CHECK;
            end
         end
         slxfp_pkg::ST_CHECK: begin
            if (accept) begin
               state_in = status.xor_hit ? slxfp_pkg::ST_READ : slxfp_pkg::ST_SYNC0;
            end
         end
         slxfp_pkg::ST_READ: begin
            state_in = slxfp_pkg::ST_EMIT;
         end
         slxfp_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.last_entry ? slxfp_pkg::ST_SYNC0 : slxfp_pkg::ST_READ;
            end
         end
         default: begin
            state_in = slxfp_pkg::ST_SYNC0;
         end
      endcase
   end

   always_comb begin
      req_tready       = 1'b0;
      cmd.take_len     = 1'b0;
      cmd.take_byte    = 1'b0;
      cmd.start_replay = 1'b0;
      cmd.read_entry   = 1'b0;
      cmd.emit         = 1'b0;
      unique case (state_ff) inside
         slxfp_pkg::ST_SYNC0, slxfp_pkg::ST_SYNC1: begin
            req_tready = 1'b1;
         end
         slxfp_pkg::ST_LEN: begin
            req_tready   = 1'b1;
            cmd.take_len = accept;
         end
         slxfp_pkg::ST_DATA: begin
            req_tready    = 1'b1;
            cmd.take_byte = accept;
         end
         slxfp_pkg::ST_CHECK: begin
            req_tready       = 1'b1;
            cmd.start_replay = accept && status.xor_hit;
         end
         slxfp_pkg::ST_READ: begin
            cmd.read_entry = 1'b1;
         end
         slxfp_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- src/slxfp_dp.sv -----
module slxfp_dp #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [7:0]                              req_tdata,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [slxfp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [7:0]                              csr_data,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [slxfp_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                    rsp_tlast,
   input  slxfp_pkg::slxfp_cmd_type                cmd,
   output slxfp_pkg::slxfp_status_type             status
);

   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   logic [7:0]       first_sync_ff;
   logic [7:0]       second_sync_ff;
   logic [CNT_W-1:0] declared_length_ff;
   logic [CNT_W-1:0] bytes_received_ff;
   logic [7:0]       running_xor_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [7:0]       rd_data_ff;
   logic [7:0]       payload_store [MAX_PAYLOAD];

   logic                            rsp_valid_ff;
   logic [7:0]                      out_byte_ff;
   logic [slxfp_pkg::INDEX_W-1:0]   out_index_ff;
   logic [slxfp_pkg::FLEN_W-1:0]    out_length_ff;
   logic                            out_last_ff;

   logic             csr_write;
   logic [CNT_W:0]   received_next;
   logic [CNT_W-1:0] rd_idx_next;
   logic             store_room;

   assign csr_write     = csr_valid && csr_ready;
   assign received_next = (CNT_W + 1)'(bytes_received_ff) + (CNT_W + 1)'(1);
   assign rd_idx_next   = CNT_W'(rd_idx_ff) + CNT_W'(1);
   assign store_room    = bytes_received_ff < CNT_W'(MAX_PAYLOAD);

   always_comb begin
      status.sync0_hit  = req_tdata == first_sync_ff;
      status.sync1_hit  = req_tdata == second_sync_ff;
      status.len_ok     = (req_tdata != 8'd0) && (req_tdata <= 8'(MAX_PAYLOAD));
      status.data_done  = received_next >= (CNT_W + 1)'(declared_length_ff);
      status.xor_hit    = req_tdata == running_xor_ff;
      status.last_entry = rd_idx_next == declared_length_ff;
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= slxfp_pkg::FIRST_SYNC_RESET;
         second_sync_ff <= slxfp_pkg::SECOND_SYNC_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            slxfp_pkg::CSR_FIRST_SYNC:  first_sync_ff  <= csr_data;
            slxfp_pkg::CSR_SECOND_SYNC: second_sync_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         declared_length_ff <= '0;
         bytes_received_ff  <= '0;
         running_xor_ff     <= '0;
         rd_idx_ff          <= '0;
      end else begin
         if (cmd.take_len) begin
            // Only a length that passed the range check is ever used.
            declared_length_ff <= CNT_W'(req_tdata);
            bytes_received_ff  <= '0;
            running_xor_ff     <= '0;
         end else if (cmd.take_byte) begin
            bytes_received_ff <= received_next[CNT_W-1:0];
            running_xor_ff    <= running_xor_ff ^ req_tdata;
         end
         if (cmd.start_replay) begin
            rd_idx_ff <= '0;
         end else if (cmd.emit && !status.last_entry) begin
            rd_idx_ff <= rd_idx_next[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte && store_room) begin
         payload_store[bytes_received_ff[IDX_W-1:0]] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_entry) begin
         rd_data_ff <= payload_store[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff   <= rd_data_ff;
         out_index_ff  <= slxfp_pkg::INDEX_W'(rd_idx_ff);
         out_length_ff <= slxfp_pkg::FLEN_W'(declared_length_ff);
         out_last_ff   <= status.last_entry;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = slxfp_pkg::RSP_TDATA_W'({out_length_ff, out_index_ff, out_byte_ff});

endmodule

// ----- src/sync_length_xor_frame_parser.sv -----
// Channel   Direction  Handshake                Contents
// req_      in         req_tvalid/req_tready    tdata[7:0] rx_byte
// rsp_      out        rsp_tvalid/rsp_tready    tdata[7:0] payload_byte,
//                                               [12:8] byte_index, [18:13] frame_length;
//                                               tlast last_byte
// csr_      in         csr_valid/csr_ready      csr_index, csr_data
//
// Each received byte is taken as soon as it is offered while the parser is hunting or reading a frame.
// A frame whose checksum matches is replayed from the payload memory one byte at a time
// (a registered memory read, then a load of the output register, for each byte), and no
// request is taken until the last byte is in the output register.
// Reset is synchronous; the parser comes up hunting for the first sync byte, no clearing pass.
// A stalled output holds its byte; requests keep flowing while it waits, except during replay.
module sync_length_xor_frame_parser #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] payload_byte, [12:8] byte_index, [18:13] frame_length, rest zero
   output logic [slxfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slxfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_data
);

   slxfp_pkg::slxfp_cmd_type    cmd;
   slxfp_pkg::slxfp_status_type status;

   assign csr_ready = 1'b1;

   slxfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   slxfp_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- src/slxfp_checker.sv -----
module slxfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [slxfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                              rsp_tlast
);

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // While a frame is still being replayed, no request is taken.
   a_replay_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during replay");

   // The bits above the frame length field are always zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[slxfp_pkg::RSP_TDATA_W-1:slxfp_pkg::RSP_FIELD_W] == '0)
      else $error("nonzero padding in result");

   // Out of reset the parser is hunting with an empty output.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind sync_length_xor_frame_parser slxfp_checker u_slxfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
